FILE: design/psoa_pkg.sv
// Shared types, codes and helpers for the obstacle-aware path smoother.
`default_nettype none
package psoa_pkg;

	localparam logic [1:0] FUNC_LOAD_MAP  = 2'd0;
	localparam logic [1:0] FUNC_LOAD_PATH = 2'd1;
	localparam logic [1:0] FUNC_RUN       = 2'd2;

	localparam logic signed [7:0] COST_LETHAL = 8'sd100;

	// result of the world-to-cell lookup
	typedef struct packed {
		logic        valid;
		logic        outside;
		logic [20:0] idx;
	} cell_res_t;

	function automatic logic [31:0] sat32(input logic signed [35:0] v);
		logic [31:0] r;
		if (v > 36'sh0_7FFF_FFFF)
			r = 32'h7FFF_FFFF;
		else if (v < -36'sh0_8000_0000)
			r = 32'h8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/psoa_cell.sv
// World position to grid cell lookup: offset, scale, range check, row-major index.
`default_nettype none
module psoa_cell (
	input  wire                logic        clk,
	input  wire                logic        arst_n,
	input  wire                logic        start,
	input  wire                logic [31:0] wx,
	input  wire                logic [31:0] wy,
	input  wire                logic [31:0] origin_x,
	input  wire                logic [31:0] origin_y,
	input  wire                logic [31:0] inv_res,
	input  wire                logic [8:0]  map_width,
	input  wire                logic [8:0]  map_height,
	output psoa_pkg::cell_res_t             res
);
	import psoa_pkg::*;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [32:0] dx_s1, dy_s1;
	logic        negx_s2, negy_s2, negx_s3, negy_s3;
	logic [31:0] magx_s2, magy_s2;
	logic [63:0] px_s3, py_s3;
	logic        out_s4;
	logic [20:0] idx_s4;
	logic [32:0] ndx, ndy;
	logic [31:0] cx, cy;
	logic        badx, bady;
	logic [16:0] idx;

	assign res = {v_s4, out_s4, idx_s4};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign ndx = -dx_s1;
	assign ndy = -dy_s1;
	assign cx  = px_s3[63:32];
	assign cy  = py_s3[63:32];
	assign badx = (negx_s3 && cx != 32'd0) || cx >= {23'd0, map_width};
	assign bady = (negy_s3 && cy != 32'd0) || cy >= {23'd0, map_height};
	assign idx = 17'(cy[7:0] * map_width) + {8'd0, cx[8:0]};

	always_ff @(posedge clk) begin
		dx_s1   <= {wx[31], wx} - {origin_x[31], origin_x};
		dy_s1   <= {wy[31], wy} - {origin_y[31], origin_y};
		// |d| never exceeds 2^32-1
		negx_s2 <= dx_s1[32];
		negy_s2 <= dy_s1[32];
		magx_s2 <= dx_s1[32] ? ndx[31:0] : dx_s1[31:0];
		magy_s2 <= dy_s1[32] ? ndy[31:0] : dy_s1[31:0];
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		px_s3   <= magx_s2 * inv_res;
		py_s3   <= magy_s2 * inv_res;
		out_s4  <= badx || bady;
		idx_s4  <= {4'd0, idx};
	end

endmodule
`default_nettype wire

FILE: design/path_smoother_obstacle_aware_core.sv
// Obstacle-aware path smoother: grid and path stores, smoothing sequencer, output stage.
// Usage:
//  Slave stream carries commands; s_tuser[1:0] selects map-cell load, path-point load or run,
//  s_tuser[2] starts a new path. Loads are accepted back to back.
//  A run smooths the stored path in place and returns one item per point on the master
//  stream, m_tlast on the final point, m_tuser set if the loaded path overflowed the store.
//  Run: a divider first forms the gain step; then each pass computes the pulls
//  (one path-store read per cycle), updates each interior point in turn
//  (gain multiply, cell lookup pipeline, grid read, write-back) and steps the gain;
//  then the items are read out one at a time, each held while the receiver stalls.
//  The single-port read of the path store and the serial point update set this order.
//  s_tready is low while a run is in progress, including while the receiver stalls;
//  a stalled output item holds in its register.
//  Configuration registers are written through cfg_we/cfg_idx/cfg_data while idle, a rule
//  for the user that the block does not enforce. Reset clears the point count, overflow
//  flag and configuration; grid and path stores hold nothing defined until loaded.
`default_nettype none
module path_smoother_obstacle_aware_core #(
	parameter int MAX_POINTS = 64,
	parameter int MAP_CELLS  = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [87:0] s_tdata,   // cell_index, cell_cost, point_x, point_y
	input  wire logic [2:0]  s_tuser,   // func, first_point
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [63:0] m_tdata,   // out_x, out_y
	output      logic        m_tlast,
	output      logic        m_tuser,   // truncated
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_data
);
	import psoa_pkg::*;

	localparam int PW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAP_CELLS);
	localparam logic [20:0] MapCells = 21'(MAP_CELLS);
	localparam logic [CW-1:0] MaxPts = CW'(MAX_POINTS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV  = 4'd1;
	localparam logic [3:0] ST_PASS = 4'd2;
	localparam logic [3:0] ST_ARD  = 4'd3;
	localparam logic [3:0] ST_ALST = 4'd4;
	localparam logic [3:0] ST_BRD  = 4'd5;
	localparam logic [3:0] ST_BMUL = 4'd6;
	localparam logic [3:0] ST_BADD = 4'd7;
	localparam logic [3:0] ST_BCEL = 4'd8;
	localparam logic [3:0] ST_BWR  = 4'd9;
	localparam logic [3:0] ST_PEND = 4'd10;
	localparam logic [3:0] ST_ERD  = 4'd11;
	localparam logic [3:0] ST_ELD  = 4'd12;
	localparam logic [3:0] ST_EWT  = 4'd13;

	localparam logic [2:0] CFG_ORG_X  = 3'd0;
	localparam logic [2:0] CFG_ORG_Y  = 3'd1;
	localparam logic [2:0] CFG_INVRES = 3'd2;
	localparam logic [2:0] CFG_WIDTH  = 3'd3;
	localparam logic [2:0] CFG_HEIGHT = 3'd4;
	localparam logic [2:0] CFG_ITERS  = 3'd5;
	localparam logic [2:0] CFG_ASTART = 3'd6;
	localparam logic [2:0] CFG_AEND   = 3'd7;

	// configuration
	logic [31:0] org_x_q, org_y_q, inv_res_q;
	logic [8:0]  width_q, height_q;
	logic [15:0] iters_q;
	logic [17:0] astart_q, aend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q   <= 32'd0;
			org_y_q   <= 32'd0;
			inv_res_q <= 32'd1310720;
			width_q   <= 9'd0;
			height_q  <= 9'd1;
			iters_q   <= 16'd100;
			astart_q  <= 18'd32768;
			aend_q    <= 18'd6554;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ORG_X:  org_x_q   <= cfg_data;
				CFG_ORG_Y:  org_y_q   <= cfg_data;
				CFG_INVRES: inv_res_q <= cfg_data;
				CFG_WIDTH:  width_q   <= cfg_data[8:0];
				CFG_HEIGHT: height_q  <= cfg_data[8:0];
				CFG_ITERS:  iters_q   <= cfg_data[15:0];
				CFG_ASTART: astart_q  <= cfg_data[17:0];
				CFG_AEND:   aend_q    <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [1:0]  in_func;
	logic        in_first;
	logic [15:0] in_cell;
	logic [7:0]  in_cost;
	logic [31:0] in_x, in_y;
	logic        acc;
	assign in_func  = s_tuser[1:0];
	assign in_first = s_tuser[2];
	assign in_cell  = s_tdata[15:0];
	assign in_cost  = s_tdata[23:16];
	assign in_x     = s_tdata[55:24];
	assign in_y     = s_tdata[87:56];

	logic [3:0] state_q;
	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;

	// grid store
	logic [7:0]    map_mem [MAP_CELLS];
	logic [7:0]    map_rd_q;
	logic [AW-1:0] map_raddr;
	logic [20:0]   ld_idx;
	cell_res_t     cres;
	assign ld_idx    = {5'd0, in_cell};
	assign map_raddr = cres.idx[AW-1:0];

	always_ff @(posedge clk) begin
		if (acc && in_func == FUNC_LOAD_MAP && ld_idx < MapCells)
			map_mem[ld_idx[AW-1:0]] <= in_cost;
		map_rd_q <= map_mem[map_raddr];
	end

	// point store: {pull_y, pull_x, y, x}
	logic [127:0]  pts_mem [MAX_POINTS];
	logic [127:0]  pts_rd_q;
	logic [127:0]  pts_wdata;
	logic [PW-1:0] pts_raddr, pts_waddr;
	logic          pts_we;

	always_ff @(posedge clk) begin
		if (pts_we)
			pts_mem[pts_waddr] <= pts_wdata;
		pts_rd_q <= pts_mem[pts_raddr];
	end

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic [CW-1:0] cnt_base;
	assign cnt_base = in_first ? '0 : cnt_q;

	// sequencer registers
	logic [4:0]    dcnt_q;
	logic [17:0]   dvd_q, qstep_q, qacc_q, alpha_q;
	logic [15:0]   rem_q, rstep_q, racc_q;
	logic          neg_q;
	logic [15:0]   k_q;
	logic [PW-1:0] ra_q, rj_q, bi_q, e_q;
	logic          rv_q;
	logic [63:0]   wa_q, wb_q;
	logic [63:0]   pull_q;
	logic [31:0]   px_q, py_q, nx_q, ny_q;
	logic signed [50:0] prx_q, pry_q;
	logic          out_q;

	// pull of point rj-1 from the window and the incoming point
	logic [63:0]        rpt;
	logic signed [32:0] sumx, sumy;
	logic signed [35:0] difx, dify;
	logic [31:0]        pullx, pully;
	assign rpt  = pts_rd_q[63:0];
	assign sumx = $signed({wa_q[31], wa_q[31:0]}) + $signed({rpt[31], rpt[31:0]});
	assign sumy = $signed({wa_q[63], wa_q[63:32]}) + $signed({rpt[63], rpt[63:32]});
	assign difx = 36'(sumx >>> 1) - 36'($signed(wb_q[31:0]));
	assign dify = 36'(sumy >>> 1) - 36'($signed(wb_q[63:32]));
	assign pullx = sat32(difx);
	assign pully = sat32(dify);

	// divider step
	logic [16:0] rsh;
	logic        rge;
	assign rsh = {rem_q, dvd_q[17]};
	assign rge = rsh >= {1'b0, iters_q};

	logic [16:0] rsum;
	assign rsum = {1'b0, racc_q} + {1'b0, rstep_q};

	logic signed [18:0] adiff;
	assign adiff = $signed({1'b0, astart_q}) - $signed({1'b0, aend_q});

	logic signed [35:0] candx, candy;
	logic [31:0]        cand_sx, cand_sy;
	assign candx = 36'($signed(px_q)) + 36'(prx_q >>> 16);
	assign candy = 36'($signed(py_q)) + 36'(pry_q >>> 16);
	assign cand_sx = sat32(candx);
	assign cand_sy = sat32(candy);

	logic blocked;
	assign blocked = (width_q != 9'd0) && (out_q || $signed(map_rd_q) >= COST_LETHAL);

	// lookup starts on the candidate itself, the same cycle it is registered
	psoa_cell u_cell (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == ST_BADD),
		.wx         (cand_sx),
		.wy         (cand_sy),
		.origin_x   (org_x_q),
		.origin_y   (org_y_q),
		.inv_res    (inv_res_q),
		.map_width  (width_q),
		.map_height (height_q),
		.res        (cres)
	);

	// store port selection
	always_comb begin
		pts_we    = 1'b0;
		pts_waddr = cnt_base[PW-1:0];
		pts_wdata = {64'd0, in_y, in_x};
		pts_raddr = ra_q;
		case (state_q)
			ST_IDLE: begin
				pts_we = acc && in_func == FUNC_LOAD_PATH && cnt_base < MaxPts;
			end
			ST_ARD, ST_ALST: begin
				pts_we    = rv_q && rj_q >= PW'(2);
				pts_waddr = rj_q - PW'(1);
				pts_wdata = {pully, pullx, wb_q};
			end
			ST_BRD: pts_raddr = bi_q;
			ST_BWR: begin
				pts_we    = !blocked;
				pts_waddr = bi_q;
				pts_wdata = {pull_q, ny_q, nx_q};
			end
			ST_ERD: pts_raddr = e_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			m_tvalid <= 1'b0;
			rv_q     <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					dcnt_q <= '0;
					rem_q  <= '0;
					neg_q  <= adiff[18];
					dvd_q  <= adiff[18] ? 18'(-adiff) : adiff[17:0];
					if (acc && in_func == FUNC_LOAD_PATH) begin
						if (cnt_base < MaxPts) begin
							cnt_q <= cnt_base + CW'(1);
							ovf_q <= in_first ? 1'b0 : ovf_q;
						end else begin
							cnt_q <= cnt_base;
							ovf_q <= 1'b1;
						end
					end else if (acc && in_func == FUNC_RUN) begin
						e_q <= '0;
						if (cnt_q >= CW'(3) && iters_q != 16'd0)
							state_q <= ST_DIV;
						else if (cnt_q != '0)
							state_q <= ST_ERD;
					end
				end
				ST_DIV: begin
					if (dcnt_q == 5'd18) begin
						qstep_q <= dvd_q;
						rstep_q <= rem_q;
						qacc_q  <= '0;
						racc_q  <= '0;
						k_q     <= '0;
						state_q <= ST_PASS;
					end else begin
						dvd_q  <= {dvd_q[16:0], rge};
						rem_q  <= rge ? 16'(rsh - {1'b0, iters_q}) : rsh[15:0];
						dcnt_q <= dcnt_q + 5'd1;
					end
				end
				ST_PASS: begin
					alpha_q <= neg_q ? astart_q + qacc_q : astart_q - qacc_q;
					ra_q    <= '0;
					rv_q    <= 1'b0;
					state_q <= ST_ARD;
				end
				ST_ARD: begin
					rv_q <= 1'b1;
					rj_q <= ra_q;
					if (CW'(ra_q) == cnt_q - CW'(1))
						state_q <= ST_ALST;
					else
						ra_q <= ra_q + PW'(1);
				end
				ST_ALST: begin
					rv_q    <= 1'b0;
					bi_q    <= PW'(1);
					state_q <= ST_BRD;
				end
				ST_BRD: state_q <= ST_BMUL;
				ST_BMUL: begin
					px_q    <= pts_rd_q[31:0];
					py_q    <= pts_rd_q[63:32];
					pull_q  <= pts_rd_q[127:64];
					prx_q   <= $signed(pts_rd_q[95:64]) * $signed({1'b0, alpha_q});
					pry_q   <= $signed(pts_rd_q[127:96]) * $signed({1'b0, alpha_q});
					state_q <= ST_BADD;
				end
				ST_BADD: begin
					nx_q    <= cand_sx;
					ny_q    <= cand_sy;
					state_q <= ST_BCEL;
				end
				ST_BCEL: begin
					if (cres.valid) begin
						out_q   <= cres.outside || cres.idx >= MapCells;
						state_q <= ST_BWR;
					end
				end
				ST_BWR: begin
					if (CW'(bi_q) == cnt_q - CW'(2)) begin
						state_q <= ST_PEND;
					end else begin
						bi_q    <= bi_q + PW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_PEND: begin
					// advance truncated gain schedule by |diff|/iterations
					if (rsum >= {1'b0, iters_q}) begin
						racc_q <= 16'(rsum - {1'b0, iters_q});
						qacc_q <= qacc_q + qstep_q + 18'd1;
					end else begin
						racc_q <= rsum[15:0];
						qacc_q <= qacc_q + qstep_q;
					end
					k_q <= k_q + 16'd1;
					if (k_q == iters_q - 16'd1)
						state_q <= ST_ERD;
					else
						state_q <= ST_PASS;
				end
				ST_ERD: state_q <= ST_ELD;
				ST_ELD: begin
					m_tvalid <= 1'b1;
					state_q  <= ST_EWT;
				end
				ST_EWT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						if (m_tlast) begin
							state_q <= ST_IDLE;
						end else begin
							e_q     <= e_q + PW'(1);
							state_q <= ST_ERD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if ((state_q == ST_ARD || state_q == ST_ALST) && rv_q) begin
			wa_q <= wb_q;
			wb_q <= rpt;
		end
		if (state_q == ST_ELD) begin
			m_tdata <= pts_rd_q[63:0];
			m_tlast <= CW'(e_q) == cnt_q - CW'(1);
			m_tuser <= ovf_q;
		end
	end

endmodule
`default_nettype wire
